// ===== design/cau_pkg.sv =====
// Package with the operation codes of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
   typedef enum logic [2:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_EQ  = 3'd4,
      KIND_NE  = 3'd5
   } kind_type;

   localparam int TOL_BITS = 17;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 17'd1;
endpackage
`default_nettype wire

// ===== design/cau_divider.sv =====
// Pipelined restoring divider giving one quotient bit per stage.
`default_nettype none
module cau_divider #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire logic [2*WORD_BITS-1:0] rem_in,
   input  wire logic [2*WORD_BITS-1:0] den_in,
   input  wire logic [WORD_BITS-1:0]   num_in,
   output logic      [WORD_BITS-1:0]   quo_out
);
   localparam int W = WORD_BITS;

   logic [2*W-1:0] rem_ff [0:W-1];
   logic [2*W-1:0] den_ff [0:W-1];
   logic [W-1:0]   num_ff [0:W-1];
   logic [W-1:0]   quo_ff [0:W-1];

   for (genvar j = 0; j < W; j++) begin : g_step
      logic [2*W-1:0] rem_prev;
      logic [2*W-1:0] den_prev;
      logic [W-1:0]   num_prev;
      logic [W-1:0]   quo_prev;
      logic [2*W+1:0] diff;
      logic           ge;
      logic [2*W-1:0] rem_in_s;
      if (j == 0) begin : g_first
         assign rem_prev = rem_in;
         assign den_prev = den_in;
         assign num_prev = num_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign num_prev = num_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end
      assign diff = {1'b0, rem_prev, num_prev[W-1]} - {2'b00, den_prev};
      assign ge = ~diff[2*W+1];
      assign rem_in_s = ge ? diff[2*W-1:0] : {rem_prev[2*W-2:0], num_prev[W-1]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in_s;
            den_ff[j] <= den_prev;
            num_ff[j] <= {num_prev[W-2:0], 1'b0};
            quo_ff[j] <= {quo_prev[W-2:0], ge};
         end
      end
   end

   assign quo_out = quo_ff[W-1];
endmodule
`default_nettype wire

// ===== design/complex_arith_unit.sv =====
// Top level of the pipelined complex arithmetic unit.
// A request carries an operation kind and two complex operands a and b in
// signed fixed point, and every request gives exactly one response.
// The configuration channel writes the zero tolerance register; csr_ready
// is always high, and writes are expected only while the unit is empty.
// The unit takes one request per cycle while req_stall is low, and
// every operation kind passes through the same stages.
// These center on the divider, which resolves one quotient bit per
// pipeline stage, ahead of which sit an input register, a multiplier
// stage and a sum stage whose outputs feed the divider setup logic
// directly, and after which sits the output register.
// Reset clears all valid bits and sets the tolerance to one.
// While a response is held by rsp_stall, the whole pipeline holds and
// req_stall is raised; when the output is empty, the pipeline advances
// and fills its bubbles.
`default_nettype none
module complex_arith_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_kind,
   input  wire logic signed [WORD_BITS-1:0] req_a_re,
   input  wire logic signed [WORD_BITS-1:0] req_a_im,
   input  wire logic signed [WORD_BITS-1:0] req_b_re,
   input  wire logic signed [WORD_BITS-1:0] req_b_im,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0]      rsp_res_re,
   output logic signed [WORD_BITS-1:0]      rsp_res_im,
   output logic                             rsp_compare_true,
   output logic                             rsp_div_by_zero,
   output logic                             rsp_overflow,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cau_pkg::TOL_BITS-1:0] csr_data
);
   import cau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NW = 2*W + 1;
   localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [W-1:0] res_re;
      logic [W-1:0] res_im;
      logic         cmp;
      logic         dz;
      logic         ovf;
      logic         is_div;
      logic         neg_re;
      logic         neg_im;
      logic         big_re;
      logic         big_im;
   } early_type;

   logic                adv;
   logic [TOL_BITS-1:0] tol_ff;

   // Input stage.
   logic                v1_ff;
   logic [2:0]          kind1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // Product stage.
   logic                v2_ff;
   logic [2:0]          kind2_ff;
   logic signed [2*W-1:0] prr_ff, pii_ff, pri_ff, pir_ff, pbb_ff, pcc_ff;
   logic [W-1:0]        as_re2_ff, as_im2_ff;
   logic                as_ovf2_ff, eq2_ff, nzb2_ff;

   // Sum stage.
   logic                v3_ff;
   logic [2:0]          kind3_ff;
   logic signed [NW-1:0] mre3_ff, mim3_ff, nre3_ff, nim3_ff;
   logic [2*W-1:0]      den3_ff;
   logic [W-1:0]        as_re3_ff, as_im3_ff;
   logic                as_ovf3_ff, eq3_ff, nzb3_ff;

   // Divider carry line and output.
   logic      vd_ff    [0:W-1];
   early_type early_ff [0:W-1];
   logic      rsp_valid_ff;
   logic [W-1:0] rsp_re_ff, rsp_im_ff;
   logic      rsp_cmp_ff, rsp_dz_ff, rsp_ovf_ff;

   assign adv = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // Stage one: register the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff <= req_kind;
         ar1_ff   <= req_a_re;
         ai1_ff   <= req_a_im;
         br1_ff   <= req_b_re;
         bi1_ff   <= req_b_im;
      end
   end

   // Products, add or subtract, and compare.
   logic signed [W:0] as_re_s, as_im_s, d_re_s, d_im_s;
   logic [W:0]        d_re_mag, d_im_mag, br_mag, bi_mag;
   logic              as_ovf_re, as_ovf_im;
   logic              is_sub;

   always_comb begin
      is_sub  = (kind1_ff == KIND_SUB);
      d_re_s  = (W+1)'(ar1_ff) - (W+1)'(br1_ff);
      d_im_s  = (W+1)'(ai1_ff) - (W+1)'(bi1_ff);
      as_re_s = is_sub ? d_re_s : (W+1)'(ar1_ff) + (W+1)'(br1_ff);
      as_im_s = is_sub ? d_im_s : (W+1)'(ai1_ff) + (W+1)'(bi1_ff);
      as_ovf_re = as_re_s[W] ^ as_re_s[W-1];
      as_ovf_im = as_im_s[W] ^ as_im_s[W-1];
      d_re_mag = d_re_s[W] ? $unsigned(-d_re_s) : $unsigned(d_re_s);
      d_im_mag = d_im_s[W] ? $unsigned(-d_im_s) : $unsigned(d_im_s);
      br_mag   = br1_ff[W-1] ? $unsigned(-(W+1)'(br1_ff)) : $unsigned((W+1)'(br1_ff));
      bi_mag   = bi1_ff[W-1] ? $unsigned(-(W+1)'(bi1_ff)) : $unsigned((W+1)'(bi1_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff   <= kind1_ff;
         prr_ff     <= ar1_ff * br1_ff;
         pii_ff     <= ai1_ff * bi1_ff;
         pri_ff     <= ar1_ff * bi1_ff;
         pir_ff     <= ai1_ff * br1_ff;
         pbb_ff     <= br1_ff * br1_ff;
         pcc_ff     <= bi1_ff * bi1_ff;
         as_re2_ff  <= as_ovf_re ? (as_re_s[W] ? MIN_VAL : MAX_VAL) : as_re_s[W-1:0];
         as_im2_ff  <= as_ovf_im ? (as_im_s[W] ? MIN_VAL : MAX_VAL) : as_im_s[W-1:0];
         as_ovf2_ff <= as_ovf_re | as_ovf_im;
         eq2_ff     <= (d_re_mag < (W+1)'(tol_ff)) && (d_im_mag < (W+1)'(tol_ff));
         nzb2_ff    <= (br_mag < (W+1)'(tol_ff)) && (bi_mag < (W+1)'(tol_ff));
      end
   end

   // Stage three: sums of products.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         kind3_ff   <= kind2_ff;
         mre3_ff    <= NW'(prr_ff) - NW'(pii_ff);
         mim3_ff    <= NW'(pri_ff) + NW'(pir_ff);
         nre3_ff    <= NW'(prr_ff) + NW'(pii_ff);
         nim3_ff    <= NW'(pir_ff) - NW'(pri_ff);
         den3_ff    <= $unsigned(pbb_ff) + $unsigned(pcc_ff);
         as_re3_ff  <= as_re2_ff;
         as_im3_ff  <= as_im2_ff;
         as_ovf3_ff <= as_ovf2_ff;
         eq3_ff     <= eq2_ff;
         nzb3_ff    <= nzb2_ff;
      end
   end

   // Multiply saturation, divider setup and results of the other kinds.
   logic signed [NW-1:0] msh_re, msh_im;
   logic [NW-W:0]        mtop_re, mtop_im;
   logic                 mfit_re, mfit_im;
   logic [NW-1:0]        nmag_re, nmag_im;
   logic [NW+F-1:0]      nsh_re, nsh_im;
   logic [NW+F-1:0]      nhi_re, nhi_im;
   logic                 dz_s;
   early_type            early_s;

   always_comb begin
      msh_re  = mre3_ff >>> F;
      msh_im  = mim3_ff >>> F;
      mtop_re = msh_re[NW-1:W-1];
      mtop_im = msh_im[NW-1:W-1];
      mfit_re = (&mtop_re) | ~(|mtop_re);
      mfit_im = (&mtop_im) | ~(|mtop_im);
      nmag_re = nre3_ff[NW-1] ? $unsigned(-nre3_ff) : $unsigned(nre3_ff);
      nmag_im = nim3_ff[NW-1] ? $unsigned(-nim3_ff) : $unsigned(nim3_ff);
      nsh_re  = {nmag_re, {F{1'b0}}};
      nsh_im  = {nmag_im, {F{1'b0}}};
      nhi_re  = nsh_re >> W;
      nhi_im  = nsh_im >> W;
      dz_s    = nzb3_ff || (den3_ff == '0);

      early_s        = '0;
      early_s.neg_re = nre3_ff[NW-1];
      early_s.neg_im = nim3_ff[NW-1];
      early_s.big_re = nhi_re >= (NW+F)'(den3_ff);
      early_s.big_im = nhi_im >= (NW+F)'(den3_ff);
      case (kind3_ff)
         KIND_ADD, KIND_SUB: begin
            early_s.res_re = as_re3_ff;
            early_s.res_im = as_im3_ff;
            early_s.ovf    = as_ovf3_ff;
         end
         KIND_MUL: begin
            early_s.res_re = mfit_re ? msh_re[W-1:0] : (msh_re[NW-1] ? MIN_VAL : MAX_VAL);
            early_s.res_im = mfit_im ? msh_im[W-1:0] : (msh_im[NW-1] ? MIN_VAL : MAX_VAL);
            early_s.ovf    = ~mfit_re | ~mfit_im;
         end
         KIND_DIV: begin
            early_s.dz     = dz_s;
            early_s.is_div = ~dz_s;
         end
         KIND_EQ: begin
            early_s.cmp = eq3_ff;
         end
         KIND_NE: begin
            early_s.cmp = ~eq3_ff;
         end
         default: begin
            early_s.cmp = 1'b0;
         end
      endcase
   end

   logic [W-1:0] quo_re, quo_im;

   cau_divider #(.WORD_BITS(W)) u_div_re (
      .clock   (clock),
      .enable  (adv),
      .rem_in  ((2*W)'(nhi_re)),
      .den_in  (den3_ff),
      .num_in  (nsh_re[W-1:0]),
      .quo_out (quo_re)
   );

   cau_divider #(.WORD_BITS(W)) u_div_im (
      .clock   (clock),
      .enable  (adv),
      .rem_in  ((2*W)'(nhi_im)),
      .den_in  (den3_ff),
      .num_in  (nsh_im[W-1:0]),
      .quo_out (quo_im)
   );

   for (genvar j = 0; j < W; j++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[j] <= 1'b0;
         end else if (adv) begin
            vd_ff[j] <= (j == 0) ? v3_ff : vd_ff[(j == 0) ? 0 : j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            early_ff[j] <= (j == 0) ? early_s : early_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // Output stage: sign and saturate the quotients, then select the result.
   early_type    fin;
   logic         qsat_re, qsat_im;
   logic [W-1:0] qval_re, qval_im;

   always_comb begin
      fin = early_ff[W-1];
      if (fin.neg_re) begin
         qsat_re = fin.big_re || (quo_re > MIN_VAL);
         qval_re = qsat_re ? MIN_VAL : (-quo_re);
      end else begin
         qsat_re = fin.big_re || quo_re[W-1];
         qval_re = qsat_re ? MAX_VAL : quo_re;
      end
      if (fin.neg_im) begin
         qsat_im = fin.big_im || (quo_im > MIN_VAL);
         qval_im = qsat_im ? MIN_VAL : (-quo_im);
      end else begin
         qsat_im = fin.big_im || quo_im[W-1];
         qval_im = qsat_im ? MAX_VAL : quo_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vd_ff[W-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_re_ff  <= fin.is_div ? qval_re : fin.res_re;
         rsp_im_ff  <= fin.is_div ? qval_im : fin.res_im;
         rsp_cmp_ff <= fin.cmp;
         rsp_dz_ff  <= fin.dz;
         rsp_ovf_ff <= fin.is_div ? (qsat_re | qsat_im) : fin.ovf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_res_re       = rsp_re_ff;
   assign rsp_res_im       = rsp_im_ff;
   assign rsp_compare_true = rsp_cmp_ff;
   assign rsp_div_by_zero  = rsp_dz_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |->
         (rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow && !rsp_compare_true))
      else $error("Divide by zero response carries nonzero fields.");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true) |->
         (rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow))
      else $error("Compare response carries arithmetic fields.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(vd_ff[W-1]) && $stable(v1_ff)))
      else $error("Pipeline moved while the response was stalled.");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("Accepted request did not enter the pipeline.");
endmodule
`default_nettype wire
